@@ rtl/ldtr_pkg.sv @@
// Package for the LFSR decryptor with tap recovery: payload structs, tap table,
// register indexes, reset values and the LFSR step function.
// No dependencies; used by the top level and its checker.
`default_nettype none

package ldtr_pkg;

	localparam int TAP_TABLE_LEN = 9;
	localparam int NUM_TAP_SETS_DEF = 9;

	localparam logic [6:0] TAP_TABLE [TAP_TABLE_LEN] = '{
		7'b1100000, 7'b1001000, 7'b1111000, 7'b1110010, 7'b1101010,
		7'b1101001, 7'b1011100, 7'b1111110, 7'b1111011
	};

	localparam logic [7:0] ERR_CODE = 8'h80;

	localparam logic [5:0] PAD_LEN_RESET = 6'd15;
	localparam logic [6:0] PAD_CHAR_RESET = 7'd32;

	typedef enum logic {
		CFG_PADDING_LENGTH = 1'b0,
		CFG_PADDING_CHAR   = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] enc_byte;
		logic       first;
	} item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       parity_error;
		logic       no_taps_found;
	} result_t;

	// One shift: the new low bit is the parity of the tapped bits.
	function automatic logic [6:0] lfsr_step(input logic [6:0] lfsr, input logic [6:0] taps);
		return {lfsr[5:0], ^(lfsr & taps)};
	endfunction

endpackage

`default_nettype wire

@@ rtl/lfsr_decrypt_with_tap_recovery.sv @@
// An accepted item is held in the input register; for a byte past the padding
// its result is then written to the output register, padding bytes give none.
// One item per cycle while not stalled: all message state is updated in one
// register stage from the input register, and a held, stalled result stalls
// a byte to emit. Reset (arst_n low, asynchronous) resets all control and
// message state and loads a padding length of 15 and a padding character of 32.
`default_nettype none

module lfsr_decrypt_with_tap_recovery #(
	parameter int NUM_TAP_SETS = ldtr_pkg::NUM_TAP_SETS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire ldtr_pkg::item_t       item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output ldtr_pkg::result_t          result,
	input  wire logic                  cfg_we,
	input  wire ldtr_pkg::cfg_index_t  cfg_index,
	input  wire logic [6:0]            cfg_wdata
);

	// Configuration registers.
	logic [5:0] pad_len_q;
	logic [6:0] pad_char_q;

	// Input register.
	logic            valid_s1;
	ldtr_pkg::item_t item_s1;

	// Message state.
	logic [6:0]              cand_q [NUM_TAP_SETS];
	logic [NUM_TAP_SETS-1:0] alive_q;
	logic [5:0]              byte_cnt_q;
	logic [6:0]              taps_q;
	logic [6:0]              chosen_q;
	logic                    in_msg_q;
	logic                    no_match_q;
	logic                    locked_q;

	// Output register.
	logic              result_valid_q;
	ldtr_pkg::result_t result_q;

	// Combinational view of the state after an optional message restart.
	logic [6:0]              cipher;
	logic [6:0]              seed;
	logic [6:0]              e_cand [NUM_TAP_SETS];
	logic [NUM_TAP_SETS-1:0] e_alive;
	logic [5:0]              e_byte_cnt;
	logic [6:0]              e_taps;
	logic [6:0]              e_chosen;
	logic                    e_in_msg;
	logic                    e_locked;

	logic                    padding_step;
	logic                    emit;
	logic [NUM_TAP_SETS-1:0] n_alive;
	logic [6:0]              n_cand [NUM_TAP_SETS];
	logic [5:0]              n_byte_cnt;
	logic                    lock_now;
	logic [6:0]              shifted;
	logic                    sel_found;
	logic [6:0]              sel_taps;
	logic [6:0]              sel_lfsr;
	logic                    perr;
	logic                    advance;
	logic                    fire_s1;

	always_comb begin
		cipher = item_s1.enc_byte[6:0];
		seed = cipher ^ pad_char_q;
		for (int i = 0; i < NUM_TAP_SETS; i++) begin
			e_cand[i] = item_s1.first ? seed : cand_q[i];
		end
		e_alive = item_s1.first ? {NUM_TAP_SETS{1'b1}} : alive_q;
		e_byte_cnt = item_s1.first ? 6'd0 : byte_cnt_q;
		e_taps = item_s1.first ? 7'd0 : taps_q;
		e_chosen = item_s1.first ? seed : chosen_q;
		e_in_msg = item_s1.first | in_msg_q;
		e_locked = item_s1.first ? 1'b0 : locked_q;

		padding_step = e_in_msg & ~e_locked;
		emit = e_in_msg & e_locked;

		// A live candidate survives a padding byte only if its keystream matches.
		for (int i = 0; i < NUM_TAP_SETS; i++) begin
			n_alive[i] = e_alive[i] & ((pad_char_q ^ e_cand[i]) == cipher);
			n_cand[i] = n_alive[i] ? ldtr_pkg::lfsr_step(e_cand[i], ldtr_pkg::TAP_TABLE[i])
				: e_cand[i];
		end

		n_byte_cnt = e_byte_cnt + 6'd1;
		lock_now = (n_byte_cnt == 6'd0) || (n_byte_cnt >= pad_len_q);
		shifted = {e_chosen[5:0], 1'b0};

		// Lowest-numbered survivor wins, so scan from the top down.
		sel_found = 1'b0;
		sel_taps = 7'd0;
		sel_lfsr = shifted;
		for (int i = NUM_TAP_SETS - 1; i >= 0; i--) begin
			if (n_alive[i]) begin
				sel_found = 1'b1;
				sel_taps = ldtr_pkg::TAP_TABLE[i];
				sel_lfsr = n_cand[i];
			end
		end

		perr = item_s1.enc_byte[7] != (^cipher);
	end

	assign advance = ~(emit & result_valid_q & result_stall);
	assign fire_s1 = valid_s1 & advance;
	assign item_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_len_q <= ldtr_pkg::PAD_LEN_RESET;
			pad_char_q <= ldtr_pkg::PAD_CHAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ldtr_pkg::CFG_PADDING_LENGTH: pad_len_q <= cfg_wdata[5:0];
				ldtr_pkg::CFG_PADDING_CHAR:   pad_char_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAP_SETS; i++) begin
				cand_q[i] <= 7'd0;
			end
			alive_q <= {NUM_TAP_SETS{1'b1}};
			byte_cnt_q <= 6'd0;
			taps_q <= 7'd0;
			chosen_q <= 7'd0;
			in_msg_q <= 1'b0;
			no_match_q <= 1'b0;
			locked_q <= 1'b0;
		end else if (fire_s1) begin
			if (padding_step) begin
				cand_q <= n_cand;
				alive_q <= n_alive;
				byte_cnt_q <= n_byte_cnt;
				in_msg_q <= 1'b1;
				locked_q <= lock_now;
				if (lock_now) begin
					taps_q <= sel_taps;
					chosen_q <= sel_lfsr;
					no_match_q <= ~sel_found;
				end else begin
					taps_q <= 7'd0;
					chosen_q <= shifted;
					no_match_q <= 1'b0;
				end
			end else if (emit) begin
				chosen_q <= ldtr_pkg::lfsr_step(e_chosen, e_taps);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			result_q.plain_byte <= perr ? ldtr_pkg::ERR_CODE : {1'b0, cipher ^ e_chosen};
			result_q.parity_error <= perr;
			result_q.no_taps_found <= no_match_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ rtl/ldtr_checker.sv @@
// Port-level checker for the LFSR decryptor with tap recovery, and its bind.
// Depends on ldtr_pkg and on the top level lfsr_decrypt_with_tap_recovery.
`default_nettype none

module ldtr_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 item_valid,
	input wire logic                 item_stall,
	input wire logic                 result_valid,
	input wire logic                 result_stall,
	input wire ldtr_pkg::result_t    result
);

	// A result that is held back stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A parity failure always carries the error code.
	a_perr_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.parity_error |-> result.plain_byte == ldtr_pkg::ERR_CODE)
		else $error("parity error without error code");

	// A good character is seven bits wide.
	a_plain_7bit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.parity_error |-> !result.plain_byte[7])
		else $error("decrypted character has bit 7 set");

	// A new result only follows an accepted input item.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without a preceding item");

endmodule

bind lfsr_decrypt_with_tap_recovery ldtr_checker u_ldtr_checker (.*);

`default_nettype wire
